[sv/qrt_pkg.sv]
`default_nettype none

package qrt_pkg;

	// table geometry, fixed by the result field widths
	localparam int SLOTS       = 8;
	localparam int PAYLOAD_CAP = 64;
	localparam int IDX_W       = $clog2(SLOTS);
	localparam int LEN_W       = 7;

	localparam logic [8:0] PUB_HDR_LEN = 9'd7;

	// configuration register indexes
	localparam logic [1:0] CFG_RETRY_INTERVAL = 2'd0;
	localparam logic [1:0] CFG_MAX_RETRIES    = 2'd1;
	localparam logic [1:0] CFG_MAX_PACKET_LEN = 2'd2;

	localparam logic [31:0] RETRY_INTERVAL_RST = 32'd5000;
	localparam logic [7:0]  MAX_RETRIES_RST    = 8'd3;
	localparam logic [7:0]  MAX_PACKET_LEN_RST = 8'd255;

	// input opcodes
	localparam logic [1:0] OP_PUBLISH = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_PUBREC  = 2'd2;
	localparam logic [1:0] OP_ACK     = 2'd3;

	localparam logic [1:0] QOS_0       = 2'd0;
	localparam logic [1:0] QOS_INVALID = 2'd3;

	// result actions
	localparam logic [3:0] ACT_NOTHING      = 4'd0;
	localparam logic [3:0] ACT_STORED       = 4'd1;
	localparam logic [3:0] ACT_FULL         = 4'd2;
	localparam logic [3:0] ACT_REJECTED     = 4'd3;
	localparam logic [3:0] ACT_RETRY_PUB    = 4'd4;
	localparam logic [3:0] ACT_RETRY_PUBREL = 4'd5;
	localparam logic [3:0] ACT_GAVE_UP      = 4'd6;
	localparam logic [3:0] ACT_SEND_PUBREL  = 4'd7;
	localparam logic [3:0] ACT_REMOVED      = 4'd8;

	typedef struct packed {
		logic [3:0]       action;
		logic [2:0]       slot;
		logic [15:0]      msg_id;
		logic [15:0]      topic_ref;
		logic [1:0]       qos;
		logic [LEN_W-1:0] body_len;
	} res_t;

	typedef struct packed {
		logic load;   // latch a new item, rewind the slot index
		logic step;   // evaluate the current slot and advance
		logic flush;  // deliver the held result as the final one
	} cmd_t;

	typedef struct packed {
		logic produce;     // current slot yields a result
		logic stop;        // scan ends with the current slot
		logic pend_valid;  // a result is held back
		logic out_free;    // output register can take a result
	} status_t;

endpackage

`default_nettype wire

[sv/qrt_ctrl.sv]
`default_nettype none

module qrt_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire qrt_pkg::status_t st,
	output qrt_pkg::cmd_t         cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// a new result pushes the held one out, so wait for room
				cmd.step = !(st.produce && st.pend_valid) || st.out_free;
				if (cmd.step && st.stop) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				cmd.flush = st.out_free;
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[sv/qrt_datapath.sv]
`default_nettype none

module qrt_datapath (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire qrt_pkg::cmd_t              cmd,
	output qrt_pkg::status_t                st,
	input  wire                             cfg_valid,
	input  wire  [1:0]                      cfg_index,
	input  wire  [31:0]                     cfg_data,
	input  wire  [1:0]                      opcode,
	input  wire  [15:0]                     msg_id,
	input  wire  [15:0]                     topic_ref,
	input  wire  [1:0]                      qos,
	input  wire  [7:0]                      body_len,
	input  wire  [31:0]                     now_ms,
	output logic                            out_valid,
	input  wire                             out_ready,
	output qrt_pkg::res_t                   out_res,
	output logic                            out_last
);

	localparam logic [qrt_pkg::IDX_W-1:0] IDX_LAST = qrt_pkg::IDX_W'(qrt_pkg::SLOTS - 1);

	// configuration
	logic [31:0] interval_q;
	logic [7:0]  max_retries_q;
	logic [7:0]  max_len_q;

	// latched item
	logic [1:0]  op_q;
	logic [15:0] mid_q;
	logic [15:0] topic_q;
	logic [1:0]  qos_q;
	logic [7:0]  plen_q;
	logic [31:0] now_q;

	// slot table
	logic                      ent_valid_q   [qrt_pkg::SLOTS];
	logic [15:0]               ent_mid_q     [qrt_pkg::SLOTS];
	logic [1:0]                ent_qos_q     [qrt_pkg::SLOTS];
	logic                      ent_step_q    [qrt_pkg::SLOTS];
	logic [31:0]               ent_time_q    [qrt_pkg::SLOTS];
	logic [7:0]                ent_retries_q [qrt_pkg::SLOTS];
	logic [15:0]               ent_topic_q   [qrt_pkg::SLOTS];
	logic [qrt_pkg::LEN_W-1:0] ent_len_q     [qrt_pkg::SLOTS];

	logic [qrt_pkg::IDX_W-1:0] idx_q;

	// held result and output register
	logic          pend_valid_q;
	qrt_pkg::res_t pend_q;
	logic          out_valid_q;
	qrt_pkg::res_t out_q;
	logic          out_last_q;

	// current slot
	logic                      cur_valid;
	logic [15:0]               cur_mid;
	logic [31:0]               cur_age;
	logic                      last_slot;
	logic                      bad_pub;
	logic                      expired;
	logic                      give_up;
	logic                      retry_fits;
	logic                      mid_hit;
	logic [qrt_pkg::LEN_W-1:0] capped_len;

	logic          produce;
	logic          stop;
	qrt_pkg::res_t res_d;
	logic          do_store;
	logic          do_clear;
	logic          do_bump;
	logic          do_rec;
	logic          out_free;
	logic          out_load;

	assign cur_valid  = ent_valid_q[idx_q];
	assign cur_mid    = ent_mid_q[idx_q];
	assign cur_age    = now_q - ent_time_q[idx_q];
	assign last_slot  = (idx_q == IDX_LAST);
	assign bad_pub    = (qos_q == qrt_pkg::QOS_INVALID) ||
	                    ((qrt_pkg::PUB_HDR_LEN + {1'b0, plen_q}) > {1'b0, max_len_q});
	assign expired    = cur_valid && (cur_age >= interval_q);
	assign give_up    = ent_retries_q[idx_q] >= max_retries_q;
	assign retry_fits = (qrt_pkg::PUB_HDR_LEN + {2'b00, ent_len_q[idx_q]}) <= {1'b0, max_len_q};
	assign mid_hit    = cur_valid && (cur_mid == mid_q);
	assign capped_len = (plen_q < 8'(qrt_pkg::PAYLOAD_CAP)) ? plen_q[qrt_pkg::LEN_W-1:0]
	                                                        : qrt_pkg::LEN_W'(qrt_pkg::PAYLOAD_CAP);

	always_comb begin
		produce  = 1'b0;
		stop     = last_slot;
		res_d    = '0;
		do_store = 1'b0;
		do_clear = 1'b0;
		do_bump  = 1'b0;
		do_rec   = 1'b0;
		unique case (op_q)
			qrt_pkg::OP_PUBLISH: begin
				stop         = 1'b1;
				res_d.msg_id = mid_q;
				priority if (bad_pub) begin
					produce      = 1'b1;
					res_d.action = qrt_pkg::ACT_REJECTED;
				end else if (qos_q == qrt_pkg::QOS_0) begin
					produce = 1'b0;
				end else if (!cur_valid) begin
					produce         = 1'b1;
					do_store        = 1'b1;
					res_d.action    = qrt_pkg::ACT_STORED;
					res_d.slot      = 3'(idx_q);
					res_d.topic_ref = topic_q;
					res_d.qos       = qos_q;
					res_d.body_len  = capped_len;
				end else if (last_slot) begin
					produce      = 1'b1;
					res_d.action = qrt_pkg::ACT_FULL;
				end else begin
					stop = 1'b0;
				end
			end
			qrt_pkg::OP_TICK: begin
				res_d.slot   = 3'(idx_q);
				res_d.msg_id = cur_mid;
				if (expired) begin
					if (give_up) begin
						produce      = 1'b1;
						do_clear     = 1'b1;
						res_d.action = qrt_pkg::ACT_GAVE_UP;
					end else if (ent_step_q[idx_q]) begin
						produce      = 1'b1;
						do_bump      = 1'b1;
						res_d.action = qrt_pkg::ACT_RETRY_PUBREL;
					end else begin
						// an over-long retry still counts but stays silent
						produce         = retry_fits;
						do_bump         = 1'b1;
						res_d.action    = qrt_pkg::ACT_RETRY_PUB;
						res_d.topic_ref = ent_topic_q[idx_q];
						res_d.qos       = ent_qos_q[idx_q];
						res_d.body_len  = ent_len_q[idx_q];
					end
				end
			end
			qrt_pkg::OP_PUBREC: begin
				res_d.action = qrt_pkg::ACT_SEND_PUBREL;
				res_d.msg_id = mid_q;
				if (mid_hit) begin
					produce    = 1'b1;
					stop       = 1'b1;
					do_rec     = 1'b1;
					res_d.slot = 3'(idx_q);
				end else begin
					// no match still answers, with slot zero
					produce = last_slot;
				end
			end
			qrt_pkg::OP_ACK: begin
				res_d.action = qrt_pkg::ACT_REMOVED;
				res_d.slot   = 3'(idx_q);
				res_d.msg_id = mid_q;
				if ((mid_q != 16'd0) && mid_hit) begin
					produce  = 1'b1;
					do_clear = 1'b1;
				end
			end
			default: begin
				stop = 1'b1;
			end
		endcase
	end

	assign out_free = !out_valid_q || out_ready;
	assign out_load = (cmd.step && produce && pend_valid_q) || cmd.flush;

	assign st.produce    = produce;
	assign st.stop       = stop;
	assign st.pend_valid = pend_valid_q;
	assign st.out_free   = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q    <= qrt_pkg::RETRY_INTERVAL_RST;
			max_retries_q <= qrt_pkg::MAX_RETRIES_RST;
			max_len_q     <= qrt_pkg::MAX_PACKET_LEN_RST;
			idx_q         <= '0;
			pend_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
			for (int i = 0; i < qrt_pkg::SLOTS; i++) begin
				ent_valid_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					qrt_pkg::CFG_RETRY_INTERVAL: interval_q    <= cfg_data;
					qrt_pkg::CFG_MAX_RETRIES:    max_retries_q <= cfg_data[7:0];
					qrt_pkg::CFG_MAX_PACKET_LEN: max_len_q     <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.step && !stop) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.step) begin
				if (do_store) begin
					ent_valid_q[idx_q] <= 1'b1;
				end else if (do_clear) begin
					ent_valid_q[idx_q] <= 1'b0;
				end
			end
			if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.step && produce) begin
				pend_valid_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			mid_q   <= msg_id;
			topic_q <= topic_ref;
			qos_q   <= qos;
			plen_q  <= body_len;
			now_q   <= now_ms;
		end
		if (cmd.step) begin
			if (do_store) begin
				ent_mid_q[idx_q]     <= mid_q;
				ent_qos_q[idx_q]     <= qos_q;
				ent_step_q[idx_q]    <= 1'b0;
				ent_time_q[idx_q]    <= now_q;
				ent_retries_q[idx_q] <= 8'd0;
				ent_topic_q[idx_q]   <= topic_q;
				ent_len_q[idx_q]     <= capped_len;
			end
			if (do_bump) begin
				ent_retries_q[idx_q] <= ent_retries_q[idx_q] + 8'd1;
				ent_time_q[idx_q]    <= now_q;
			end
			if (do_rec) begin
				ent_step_q[idx_q] <= 1'b1;
				ent_time_q[idx_q] <= now_q;
			end
			if (produce) begin
				pend_q <= res_d;
			end
		end
		if (out_load) begin
			if (cmd.flush) begin
				out_q      <= pend_valid_q ? pend_q : '0;
				out_last_q <= 1'b1;
			end else begin
				out_q      <= pend_q;
				out_last_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

[sv/qos_retry_tracker_unit.sv]
`default_nettype none

// bus  handshake            fields
// cfg  cfg_valid/cfg_ready  cfg_index, cfg_data
// in   in_valid/in_ready    opcode, msg_id, topic_ref, qos, body_len, now_ms
// out  out_valid/out_ready  action, slot, out_msg_id, out_topic_ref, out_qos, out_body_len, last
//
// one item at a time: the item is accepted, then the table is scanned one slot per cycle while no
// stalled output holds the scan (publish and pubrec stop at their slot, tick and ack walk all 8),
// and then the final result is delivered
// each result is held back until the next one is produced so that the final one can carry last
// a stalled output holds the scan at the next result; configuration is taken any cycle
// reset clears the valid bits of the table and loads the register defaults

module qos_retry_tracker_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [31:0] cfg_data,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  opcode,
	input  wire  [15:0] msg_id,
	input  wire  [15:0] topic_ref,
	input  wire  [1:0]  qos,
	input  wire  [7:0]  body_len,
	input  wire  [31:0] now_ms,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [3:0]  action,
	output logic [2:0]  slot,
	output logic [15:0] out_msg_id,
	output logic [15:0] out_topic_ref,
	output logic [1:0]  out_qos,
	output logic [6:0]  out_body_len,
	output logic        last
);

	qrt_pkg::cmd_t    cmd;
	qrt_pkg::status_t st;
	qrt_pkg::res_t    res;

	assign cfg_ready = 1'b1;

	qrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	qrt_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.opcode    (opcode),
		.msg_id    (msg_id),
		.topic_ref (topic_ref),
		.qos       (qos),
		.body_len  (body_len),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res),
		.out_last  (last)
	);

	assign action        = res.action;
	assign slot          = res.slot;
	assign out_msg_id    = res.msg_id;
	assign out_topic_ref = res.topic_ref;
	assign out_qos       = res.qos;
	assign out_body_len  = res.body_len;

endmodule

`default_nettype wire

[sv/qrt_checker.sv]
`default_nettype none

module qrt_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [3:0]  action,
	input wire [2:0]  slot,
	input wire [15:0] out_msg_id,
	input wire        last
);

	// a stalled result holds its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) && $stable(slot) &&
		$stable(out_msg_id) && $stable(last))
		else $error("output changed while stalled");

	// only one transaction in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in progress");

	a_action_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> action <= qrt_pkg::ACT_REMOVED)
		else $error("unknown action");

	// single-result answers always close the transaction
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == qrt_pkg::ACT_NOTHING || action == qrt_pkg::ACT_STORED ||
		action == qrt_pkg::ACT_FULL || action == qrt_pkg::ACT_REJECTED ||
		action == qrt_pkg::ACT_SEND_PUBREL) |-> last)
		else $error("single result without last");

	a_nothing_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == qrt_pkg::ACT_NOTHING |-> slot == 3'd0 && out_msg_id == 16'd0)
		else $error("empty result carries data");

endmodule

bind qos_retry_tracker_unit qrt_checker u_qrt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.action     (action),
	.slot       (slot),
	.out_msg_id (out_msg_id),
	.last       (last)
);

`default_nettype wire
